FILE: hdl/tsf_pkg.sv
// ----------------------------------------------------------------------------
// Touch sample filter package
// Shared payload types, touch codes, operation codes and size constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsf_pkg;

  // Coordinate width of one axis
  localparam int COORD_W = 10;

  // Default set size and register reset value
  localparam int             SAMPLES_PER_SET_DEF = 8;
  localparam logic [7:0]     TIMEOUT_RESET       = 8'd100;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Operation codes on the request channel
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_POLL   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Touch codes
  localparam logic [2:0] CODE_NO_TOUCH = 3'd0;
  localparam logic [2:0] CODE_TOUCH    = 3'd1;
  localparam logic [2:0] CODE_HELD     = 3'd2;
  localparam logic [2:0] CODE_RELEASE  = 3'd3;
  localparam logic [2:0] CODE_NO_CAL   = 3'd4;

  // Request transaction
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] x_high;
    logic [7:0] y_high;
    logic [7:0] xy_low;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic [2:0]         touch_code;
    logic               coords_valid;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
  } rsp_t;

  // Classified command kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_POLL   = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } cmd_kind_t;

  // Command held in the queue
  typedef struct packed {
    cmd_kind_t          kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } cmd_t;

  // Control from the sequencer to the trimmed mean units
  typedef struct packed {
    logic push;
    logic start;
  } trim_ctl_t;

endpackage

FILE: hdl/tsf_front.sv
// ----------------------------------------------------------------------------
// Touch sample filter front end
// Accepts request transactions, assembles the 10-bit coordinates and
// classifies the operation into a queue command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsf_front (
  input  logic           req_valid,
  output logic           req_ready,
  input  tsf_pkg::req_t  req,
  input  logic           queue_full,
  output logic           push,
  output tsf_pkg::cmd_t  cmd
);
  import tsf_pkg::*;

  // Accept whenever the queue has room
  assign req_ready = !queue_full;
  assign push      = req_valid && !queue_full;

  // Classify and assemble coordinates
  always_comb begin
    cmd.x = {req.x_high, req.xy_low[1:0]};
    cmd.y = {req.y_high, req.xy_low[3:2]};
    unique case (req.operation)
      OP_SAMPLE: cmd.kind = KIND_SAMPLE;
      OP_POLL:   cmd.kind = KIND_POLL;
      OP_TICK:   cmd.kind = KIND_TICK;
      default:   cmd.kind = KIND_NONE;
    endcase
  end

endmodule

FILE: hdl/tsf_queue.sv
// ----------------------------------------------------------------------------
// Touch sample filter command queue
// Short register queue that decouples the front end from the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsf_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tsf_pkg::cmd_t  head
);
  import tsf_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [FW-1:0]   fill;
  logic            do_push;
  logic            do_pop;

  assign full       = (fill == FW'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/tsf_trim.sv
// ----------------------------------------------------------------------------
// Touch sample filter trimmed mean unit
// Holds one axis of the sample set in a shift line, ranks one sample per
// cycle while rotating the line, sums the middle ranks and scales the sum by
// the reciprocal of the kept count with a single multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsf_trim #(
  parameter int SAMPLES_PER_SET = tsf_pkg::SAMPLES_PER_SET_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tsf_pkg::trim_ctl_t          ctl,
  input  logic [tsf_pkg::COORD_W-1:0] sample,
  output logic                        done,
  output logic [tsf_pkg::COORD_W-1:0] avg
);
  import tsf_pkg::*;

  localparam int N    = SAMPLES_PER_SET;
  localparam int SW   = $clog2(N);
  localparam int RW   = SW + 1;
  localparam int LO   = N / 4;
  localparam int HI   = N - N / 4;
  localparam int KEEP = HI - LO;
  localparam int AW   = COORD_W + SW;
  // Reciprocal of the kept count, exact for every sum below 2**AW
  localparam int KW   = $clog2(KEEP);
  localparam int SH   = AW + KW;
  localparam int MW   = AW + 1;
  localparam int PRW  = AW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(KEEP) - 64'd1) / 64'(KEEP));

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_RANK = 4'b0010,
    T_SUM  = 4'b0100,
    T_DIV  = 4'b1000
  } trim_fsm_t;

  trim_fsm_t            state;
  logic [COORD_W-1:0]   store [N];
  logic [SW-1:0]        step;
  logic                 keep_q;
  logic [COORD_W-1:0]   cur_q;
  logic [AW-1:0]        acc;
  logic [AW-1:0]        acc_sum;
  logic [AW-1:0]        rem;
  logic [PRW-1:0]       prod;
  logic [COORD_W-1:0]   quot;
  logic [N-1:0]         rank_bits;
  logic [RW-1:0]        rank;
  logic [RW-1:0]        thr;
  logic                 keep;

  // Shift in new samples; rotate the line while ranking
  always_ff @(posedge clk) begin
    if (ctl.push || state == T_RANK) begin
      store[N-1] <= ctl.push ? sample : store[0];
      for (int p = 0; p < N - 1; p++) begin
        store[p] <= store[p+1];
      end
    end
  end

  // Rank of the head sample: smaller values, plus equal values stored earlier
  always_comb begin
    thr       = RW'(N) - RW'(step);
    rank_bits = '0;
    for (int p = 0; p < N; p++) begin
      if (store[p] < store[0]) begin
        rank_bits[p] = 1'b1;
      end else if (store[p] == store[0] && RW'(p) >= thr) begin
        rank_bits[p] = 1'b1;
      end
    end
    rank = '0;
    for (int p = 0; p < N; p++) begin
      rank = rank + RW'(rank_bits[p]);
    end
    keep = (rank >= RW'(LO)) && (rank < RW'(HI));
  end

  assign acc_sum = acc + (keep_q ? AW'(cur_q) : '0);
  assign prod    = PRW'(rem) * PRW'(RECIP);
  assign avg     = quot;

  // Sequence rank, sum and scale phases
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == T_DIV);
      unique case (state)
        T_IDLE: if (ctl.start) state <= T_RANK;
        T_RANK: if (step == SW'(N - 1)) state <= T_SUM;
        T_SUM:  state <= T_DIV;
        T_DIV:  state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end

  // Datapath: accumulate kept samples, then scale by the reciprocal
  always_ff @(posedge clk) begin
    unique case (state)
      T_IDLE: begin
        step   <= '0;
        acc    <= '0;
        keep_q <= 1'b0;
      end
      T_RANK: begin
        acc    <= acc_sum;
        keep_q <= keep;
        cur_q  <= store[0];
        step   <= step + 1'b1;
      end
      T_SUM: begin
        rem <= acc_sum;
      end
      T_DIV: begin
        quot <= prod[SH +: COORD_W];
      end
      default: begin
        step <= '0;
      end
    endcase
  end

endmodule

FILE: hdl/tsf_back.sv
// ----------------------------------------------------------------------------
// Touch sample filter sequencer
// Executes queued commands against the touch state, counts samples and idle
// ticks, starts the trimmed mean units on a full set and fills the response
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsf_back #(
  parameter int SAMPLES_PER_SET = tsf_pkg::SAMPLES_PER_SET_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [7:0]                  timeout,
  input  logic                        cmd_valid,
  input  tsf_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  output tsf_pkg::trim_ctl_t          trim_ctl,
  input  logic                        trim_done,
  input  logic [tsf_pkg::COORD_W-1:0] trim_x,
  input  logic [tsf_pkg::COORD_W-1:0] trim_y,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output tsf_pkg::rsp_t               rsp
);
  import tsf_pkg::*;

  localparam int N  = SAMPLES_PER_SET;
  localparam int SW = $clog2(N);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_WAIT = 2'b10
  } back_fsm_t;

  back_fsm_t            state;
  back_fsm_t            state_next;
  logic [2:0]           touch_state;
  logic [2:0]           touch_state_next;
  logic [SW-1:0]        sample_count;
  logic [SW-1:0]        sample_count_next;
  logic [7:0]           idle_periods;
  logic [7:0]           idle_periods_next;
  logic [COORD_W-1:0]   avg_x;
  logic [COORD_W-1:0]   avg_x_next;
  logic [COORD_W-1:0]   avg_y;
  logic [COORD_W-1:0]   avg_y_next;
  logic                 out_free;
  logic                 take;
  logic                 active;
  logic                 emit;
  logic [2:0]           emit_code;
  logic                 emit_valid;

  assign out_free = !rsp_valid || rsp_ready;
  assign take     = (state == B_IDLE) && cmd_valid && out_free;
  assign cmd_pop  = take;
  assign active   = (touch_state == CODE_TOUCH) || (touch_state == CODE_HELD);

  // Execute one command, or finish a set when the averages are ready
  always_comb begin
    state_next        = state;
    touch_state_next  = touch_state;
    sample_count_next = sample_count;
    idle_periods_next = idle_periods;
    avg_x_next        = avg_x;
    avg_y_next        = avg_y;
    trim_ctl          = '0;
    emit              = 1'b0;
    emit_code         = touch_state;
    emit_valid        = 1'b0;

    unique case (state)
      B_IDLE: begin
        if (take) begin
          unique case (cmd.kind)
            KIND_SAMPLE: begin
              idle_periods_next = '0;
              trim_ctl.push     = 1'b1;
              if (sample_count == SW'(N - 1)) begin
                sample_count_next = '0;
                trim_ctl.start    = 1'b1;
                state_next        = B_WAIT;
              end else begin
                sample_count_next = sample_count + 1'b1;
                emit              = 1'b1;
                if (active) begin
                  touch_state_next = CODE_HELD;
                  emit_code        = CODE_HELD;
                  emit_valid       = 1'b1;
                end
              end
            end
            KIND_POLL: begin
              emit = 1'b1;
              if (active) begin
                touch_state_next = CODE_HELD;
                emit_code        = CODE_HELD;
                emit_valid       = 1'b1;
              end else if (touch_state == CODE_RELEASE) begin
                touch_state_next = CODE_NO_TOUCH;
                emit_code        = CODE_RELEASE;
                emit_valid       = 1'b1;
              end
            end
            KIND_TICK: begin
              emit = 1'b1;
              if (idle_periods >= timeout) begin
                sample_count_next = '0;
                idle_periods_next = '0;
                touch_state_next  = (touch_state == CODE_HELD) ? CODE_RELEASE
                                                               : CODE_NO_TOUCH;
              end else begin
                idle_periods_next = idle_periods + 1'b1;
              end
              emit_code = touch_state_next;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      B_WAIT: begin
        if (trim_done) begin
          avg_x_next       = trim_x;
          avg_y_next       = trim_y;
          touch_state_next = active ? CODE_HELD : CODE_TOUCH;
          emit             = 1'b1;
          emit_code        = touch_state_next;
          emit_valid       = 1'b1;
          state_next       = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Hold touch state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      touch_state  <= CODE_NO_CAL;
      sample_count <= '0;
      idle_periods <= '0;
      avg_x        <= '0;
      avg_y        <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      touch_state  <= touch_state_next;
      sample_count <= sample_count_next;
      idle_periods <= idle_periods_next;
      avg_x        <= avg_x_next;
      avg_y        <= avg_y_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Load the response register
  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.touch_code   <= emit_code;
      rsp.coords_valid <= emit_valid;
      rsp.out_x        <= avg_x_next;
      rsp.out_y        <= avg_y_next;
    end
  end

endmodule

FILE: hdl/touch_sample_trimmed_mean_filter.sv
// ----------------------------------------------------------------------------
// Touch sample trimmed mean filter
// Qualifies resistive touch samples: collects sets, averages the middle half
// of each axis and tracks touch, held, release and idle timeout.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one operation: a sample, a poll or an
//   idle tick. rsp channel (valid/ready) returns exactly one transaction per
//   request, in order: touch code, coordinate valid flag and last averages.
//   cfg_we writes cfg_wdata into the idle timeout register;
//   write it only while no request is outstanding.
// Sequencing:
//   A poll, tick or sample that does not complete a set passes from the
//   queue to the response register, and the sequencer takes one such
//   transaction per cycle while idle with the response register free.
//   The sample that completes a set occupies the sequencer for the take, a
//   rank step for each stored sample, the sum, the reciprocal multiply and
//   the loading of the response, both axes side by side.
// Reset: the touch state reads not calibrated, counters and averages clear
//   and the timeout returns to 100 periods.
// Stall: a two-entry queue keeps accepting while the response register waits;
//   once it fills, req_ready drops until the receiver takes the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_sample_trimmed_mean_filter #(
  parameter int SAMPLES_PER_SET = tsf_pkg::SAMPLES_PER_SET_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tsf_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output tsf_pkg::rsp_t  rsp,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata
);
  import tsf_pkg::*;

  logic [7:0]         timeout_periods;
  logic               front_push;
  cmd_t               front_cmd;
  logic               queue_full;
  logic               head_valid;
  cmd_t               head;
  logic               head_pop;
  trim_ctl_t          trim_ctl;
  logic               x_done;
  logic               y_done;
  logic [COORD_W-1:0] x_avg;
  logic [COORD_W-1:0] y_avg;

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_periods <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_periods <= cfg_wdata;
    end
  end

  tsf_front u_front (
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .queue_full (queue_full),
    .push       (front_push),
    .cmd        (front_cmd)
  );

  tsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_push),
    .push_cmd   (front_cmd),
    .full       (queue_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tsf_trim #(.SAMPLES_PER_SET(SAMPLES_PER_SET)) u_trim_x (
    .clk    (clk),
    .rst    (rst),
    .ctl    (trim_ctl),
    .sample (head.x),
    .done   (x_done),
    .avg    (x_avg)
  );

  tsf_trim #(.SAMPLES_PER_SET(SAMPLES_PER_SET)) u_trim_y (
    .clk    (clk),
    .rst    (rst),
    .ctl    (trim_ctl),
    .sample (head.y),
    .done   (y_done),
    .avg    (y_avg)
  );

  tsf_back #(.SAMPLES_PER_SET(SAMPLES_PER_SET)) u_back (
    .clk       (clk),
    .rst       (rst),
    .timeout   (timeout_periods),
    .cmd_valid (head_valid),
    .cmd       (head),
    .cmd_pop   (head_pop),
    .trim_ctl  (trim_ctl),
    .trim_done (x_done),
    .trim_x    (x_avg),
    .trim_y    (y_avg),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Both axes run in lock step
  a_axes_lockstep: assert property (@(posedge clk) disable iff (rst)
    x_done == y_done)
    else $error("trimmed mean units out of step");

  // A finished set never meets a pending response
  a_done_out_free: assert property (@(posedge clk) disable iff (rst)
    x_done |-> !rsp_valid)
    else $error("set finished while a response was pending");

  // A finished set is reported with valid coordinates
  a_done_reported: assert property (@(posedge clk) disable iff (rst)
    x_done |=> rsp_valid && rsp.coords_valid)
    else $error("finished set not reported");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Touch sample filter testbench
// Drives samples, polls, idle ticks and unused operations through the
// valid/ready request channel with random gaps and response stalls, and
// checks every response against an in-bench model of the touch qualifier
// (trimmed mean of each full set, touch/held/release tracking, idle timeout)
// across several timeout register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import tsf_pkg::*;

typedef logic [COORD_W-1:0] axis_set_t [SAMPLES_PER_SET_DEF];

// Expected touch reports and the qualifier state that produces them
class touch_scoreboard;
  axis_set_t   x_store;
  axis_set_t   y_store;
  int          stored;
  logic [9:0]  avg_x;
  logic [9:0]  avg_y;
  logic [2:0]  touch_state;
  logic [7:0]  idle_count;
  logic [7:0]  timeout;
  rsp_t        expected_reports[$];
  int          mismatches;
  int          reports_checked;
  int          sets_done;
  int          timeouts_fired;

  function new();
    stored      = 0;
    avg_x       = '0;
    avg_y       = '0;
    touch_state = CODE_NO_CAL;
    idle_count  = '0;
    timeout     = TIMEOUT_RESET;
    mismatches  = 0;
    reports_checked = 0;
    sets_done   = 0;
    timeouts_fired = 0;
  endfunction

  function void set_timeout(logic [7:0] value);
    timeout = value;
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction

  function bit is_active();
    return touch_state == CODE_TOUCH || touch_state == CODE_HELD;
  endfunction

  // Sort a copy of one axis, drop the outer quarters and average the rest
  function logic [COORD_W-1:0] trimmed_avg(axis_set_t v);
    axis_set_t          s;
    logic [COORD_W-1:0] cur;
    int                 k;
    int unsigned        sum;
    s = v;
    for (int i = 1; i < SAMPLES_PER_SET_DEF; i++) begin
      cur = s[i];
      k = i;
      while (k > 0 && s[k-1] > cur) begin
        s[k] = s[k-1];
        k--;
      end
      s[k] = cur;
    end
    sum = 0;
    for (int i = SAMPLES_PER_SET_DEF / 4;
         i < SAMPLES_PER_SET_DEF - SAMPLES_PER_SET_DEF / 4; i++)
      sum += s[i];
    sum = sum / (SAMPLES_PER_SET_DEF - 2 * (SAMPLES_PER_SET_DEF / 4));
    return sum[COORD_W-1:0];
  endfunction

  // Advance the qualifier by one request and return its report
  function rsp_t qualify_touch(req_t r);
    rsp_t       o;
    logic [2:0] code;
    logic       vld;
    code = touch_state;
    vld  = 1'b0;
    case (r.operation)
      OP_SAMPLE: begin
        idle_count = '0;
        if (stored >= SAMPLES_PER_SET_DEF) stored = 0;
        x_store[stored] = {r.x_high, r.xy_low[1:0]};
        y_store[stored] = {r.y_high, r.xy_low[3:2]};
        stored++;
        if (stored == SAMPLES_PER_SET_DEF) begin
          avg_y = trimmed_avg(y_store);
          avg_x = trimmed_avg(x_store);
          touch_state = is_active() ? CODE_HELD : CODE_TOUCH;
          stored = 0;
          code = touch_state;
          vld = 1'b1;
          sets_done++;
        end else if (is_active()) begin
          touch_state = CODE_HELD;
          code = CODE_HELD;
          vld = 1'b1;
        end
      end
      OP_POLL: begin
        if (is_active()) begin
          touch_state = CODE_HELD;
          code = CODE_HELD;
          vld = 1'b1;
        end else if (touch_state == CODE_RELEASE) begin
          code = CODE_RELEASE;
          vld = 1'b1;
          touch_state = CODE_NO_TOUCH;
        end
      end
      OP_TICK: begin
        if (idle_count >= timeout) begin
          stored = 0;
          touch_state = (touch_state == CODE_HELD) ? CODE_RELEASE : CODE_NO_TOUCH;
          idle_count = '0;
          timeouts_fired++;
        end else begin
          idle_count = idle_count + 8'd1;
        end
        code = touch_state;
      end
      default: ;
    endcase
    o.touch_code   = code;
    o.coords_valid = vld;
    o.out_x        = avg_x;
    o.out_y        = avg_y;
    return o;
  endfunction

  function void note_request(req_t r);
    expected_reports.push_back(qualify_touch(r));
  endfunction

  // Compare one accepted response with the oldest expected report
  function void check_response(rsp_t got);
    rsp_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: unexpected response, expected none, got code %0d valid %0d x %0d y %0d",
               $time, got.touch_code, got.coords_valid, got.out_x, got.out_y);
      mismatches++;
      return;
    end
    want = expected_reports.pop_front();
    reports_checked++;
    if (got.touch_code !== want.touch_code) begin
      $display("%0t: touch_code mismatch, expected %0d, got %0d",
               $time, want.touch_code, got.touch_code);
      mismatches++;
    end
    if (got.coords_valid !== want.coords_valid) begin
      $display("%0t: coords_valid mismatch, expected %0d, got %0d",
               $time, want.coords_valid, got.coords_valid);
      mismatches++;
    end
    if (got.out_x !== want.out_x) begin
      $display("%0t: out_x mismatch, expected %0d, got %0d", $time, want.out_x, got.out_x);
      mismatches++;
    end
    if (got.out_y !== want.out_y) begin
      $display("%0t: out_y mismatch, expected %0d, got %0d", $time, want.out_y, got.out_y);
      mismatches++;
    end
  endfunction
endclass

module tb_top;

  localparam int         SET_N        = SAMPLES_PER_SET_DEF;
  localparam int         DRAIN_CYCLES = SAMPLES_PER_SET_DEF + 24;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  req_t       req_bits = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_t       rsp_bits;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  bit              calm = 1'b0;
  int              sent_count = 0;
  int              settings_used = 0;
  touch_scoreboard board = new();

  touch_sample_trimmed_mean_filter #(
    .SAMPLES_PER_SET(SET_N)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_bits),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp_bits),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the response channel at random, except during the calm phase
  initial begin
    forever begin
      @(negedge clk);
      rsp_ready = calm ? 1'b1 : ($urandom_range(99) >= 36);
    end
  end

  // Check each response transaction as it is taken
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_response(rsp_bits);
  end

  function automatic req_t mk(logic [1:0] op, logic [7:0] xh, logic [7:0] yh,
                              logic [7:0] xl);
    req_t r;
    r.operation = op;
    r.x_high    = xh;
    r.y_high    = yh;
    r.xy_low    = xl;
    return r;
  endfunction

  function automatic req_t pack_sample(logic [9:0] xv, logic [9:0] yv);
    return mk(OP_SAMPLE, xv[9:2], yv[9:2], {4'($urandom_range(15)), yv[1:0], xv[1:0]});
  endfunction

  // Non-sample operation with random filler in the coordinate fields
  function automatic req_t other_req(logic [1:0] op);
    return mk(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
  endfunction

  function automatic logic [9:0] jitter(logic [9:0] c);
    int v;
    v = int'(c) + int'($urandom_range(24)) - 12;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[9:0];
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_req(input req_t item);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 36) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req_bits  = item;
    do @(posedge clk); while (!req_ready);
    board.note_request(item);
    sent_count++;
  endtask

  // Drain outstanding work, then write the idle timeout register
  task automatic write_timeout(input logic [7:0] value);
    @(negedge clk);
    req_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_timeout(value);
    settings_used++;
  endtask

  // Samples clustered around one point, with the odd poll, tick or outlier
  task automatic send_set(input int len);
    logic [9:0] cx;
    logic [9:0] cy;
    cx = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 10'd1023 : 10'd0)
                                  : 10'($urandom_range(1023));
    cy = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 10'd1023 : 10'd0)
                                  : 10'($urandom_range(1023));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 12) send_req(other_req(OP_POLL));
      else if ($urandom_range(99) < 5) send_req(other_req(OP_TICK));
      if ($urandom_range(4) == 0)
        send_req(pack_sample(10'($urandom_range(1023)), 10'($urandom_range(1023))));
      else
        send_req(pack_sample(jitter(cx), jitter(cy)));
    end
  endtask

  // One random phase under a given timeout setting
  task automatic run_phase(input logic [7:0] t, input int n, input bit quiet);
    int first;
    int pick;
    int run;
    int long_runs;
    write_timeout(t);
    calm = quiet;
    first = sent_count;
    long_runs = 0;
    while (sent_count - first < n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_set(SET_N);
      end else if (pick < 55) begin
        send_set($urandom_range(1, SET_N - 1));
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 3)) send_req(other_req(OP_POLL));
      end else if (pick < 93) begin
        if (t <= 20) begin
          run = $urandom_range(1, int'(t) + 3);
        end else if (long_runs == 0 && $urandom_range(1) == 0) begin
          run = int'(t) + 2;
          long_runs++;
        end else begin
          run = $urandom_range(1, 6);
        end
        repeat (run) send_req(other_req(OP_TICK));
      end else begin
        send_req(other_req(OP_UNUSED));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset state: not calibrated, unused code, first tick
    send_req(mk(OP_POLL, 8'h00, 8'h00, 8'h00));
    send_req(mk(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF));
    send_req(mk(OP_TICK, 8'hFF, 8'h00, 8'hF0));
    // First full set from field extremes gives touch
    send_req(mk(OP_SAMPLE, 8'h00, 8'h00, 8'h00));
    send_req(mk(OP_SAMPLE, 8'hFF, 8'hFF, 8'hFF));
    send_req(mk(OP_SAMPLE, 8'hFF, 8'h00, 8'h03));
    send_req(mk(OP_SAMPLE, 8'h00, 8'hFF, 8'h0C));
    send_req(mk(OP_SAMPLE, 8'h80, 8'h7F, 8'hF5));
    send_req(mk(OP_SAMPLE, 8'h01, 8'hFE, 8'h0A));
    send_req(mk(OP_SAMPLE, 8'hAA, 8'h55, 8'h50));
    send_req(mk(OP_SAMPLE, 8'h55, 8'hAA, 8'hA6));
    // Poll and a partial sample while touched report held
    send_req(mk(OP_POLL, 8'h12, 8'h34, 8'h56));
    send_req(mk(OP_SAMPLE, 8'hFF, 8'hFF, 8'h0F));

    // Timeout of one: held drops to release, reported once by a poll
    write_timeout(8'd1);
    send_req(mk(OP_TICK, 8'h00, 8'h00, 8'h00));
    send_req(mk(OP_TICK, 8'h00, 8'h00, 8'h00));
    send_req(mk(OP_POLL, 8'h00, 8'h00, 8'h00));
    send_req(mk(OP_POLL, 8'h00, 8'h00, 8'h00));
    send_req(mk(OP_TICK, 8'h00, 8'h00, 8'h00));
    send_req(mk(OP_TICK, 8'h00, 8'h00, 8'h00));

    // Zero timeout fires on every tick
    write_timeout(8'd0);
    send_req(mk(OP_TICK, 8'hFF, 8'hFF, 8'hFF));

    // Random phases over several settings, one of them without random gaps or response stalls
    run_phase(8'd3, 60, 1'b0);
    run_phase(8'd0, 60, 1'b0);
    run_phase(8'd255, 60, 1'b0);
    run_phase(TIMEOUT_RESET, 60, 1'b1);
    run_phase(8'($urandom_range(1, 12)), 60, 1'b0);
    run_phase(8'd1, 60, 1'b0);
    run_phase(8'($urandom_range(1, 255)), 60, 1'b0);

    // Let the last responses out
    @(negedge clk);
    req_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d responses under %0d timeout settings;",
             sent_count, board.reports_checked, settings_used);
    $display("%0d full sets averaged, %0d idle timeouts fired, %0d mismatches.",
             board.sets_done, board.timeouts_fired, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("Timeout with %0d responses outstanding", board.pending());
    $display("tb_top failed");
    $finish;
  end

endmodule
